### design/abd_pkg.sv
package abd_pkg;

  localparam int unsigned LogitW = 16;
  localparam int unsigned CellW  = 7;
  localparam int unsigned LvlW   = 2;
  localparam int unsigned ConfW  = 16;
  localparam int unsigned CoordW = 16;

  localparam logic [ConfW-1:0] ConfThreshReset = 16'd16384;

  typedef struct packed {
    logic signed [LogitW-1:0] tx_logit;
    logic signed [LogitW-1:0] ty_logit;
    logic signed [LogitW-1:0] tw_logit;
    logic signed [LogitW-1:0] th_logit;
    logic signed [LogitW-1:0] obj_logit;
    logic signed [LogitW-1:0] fire_logit;
    logic signed [LogitW-1:0] like_logit;
    logic [CellW-1:0]         cell_col;
    logic [CellW-1:0]         cell_row;
    logic [LvlW-1:0]          scale_level;
    logic [LvlW-1:0]          anchor_slot;
  } cell_t;

  typedef struct packed {
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_right;
    logic signed [CoordW-1:0] box_top;
    logic signed [CoordW-1:0] box_bottom;
    logic [ConfW-1:0]         box_score;
  } box_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic [16:0]     sx;
    logic [16:0]     sy;
    logic [16:0]     sw;
    logic [16:0]     sh;
    logic [16:0]     obj;
    logic [16:0]     fire;
    logic [CellW-1:0] col;
    logic [CellW-1:0] row;
    logic [LvlW-1:0]  lvl;
    logic [8:0]       anc_w;
    logic [8:0]       anc_h;
  } work_t;

  function automatic logic [16:0] sig_tab(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0: v = 17'd32768;   6'd1: v = 17'd36843;   6'd2: v = 17'd40793;
      6'd3: v = 17'd44510;   6'd4: v = 17'd47910;   6'd5: v = 17'd50941;
      6'd6: v = 17'd53581;   6'd7: v = 17'd55833;   6'd8: v = 17'd57724;
      6'd9: v = 17'd59287;   6'd10: v = 17'd60565;  6'd11: v = 17'd61597;
      6'd12: v = 17'd62427;  6'd13: v = 17'd63090;  6'd14: v = 17'd63615;
      6'd15: v = 17'd64030;  6'd16: v = 17'd64357;  6'd17: v = 17'd64614;
      6'd18: v = 17'd64816;  6'd19: v = 17'd64974;  6'd20: v = 17'd65097;
      6'd21: v = 17'd65194;  6'd22: v = 17'd65269;  6'd23: v = 17'd65328;
      6'd24: v = 17'd65374;  6'd25: v = 17'd65410;  6'd26: v = 17'd65437;
      6'd27: v = 17'd65459;  6'd28: v = 17'd65476;  6'd29: v = 17'd65489;
      6'd30: v = 17'd65500;  6'd31: v = 17'd65508;  default: v = 17'd65514;
    endcase
    return v;
  endfunction

  // sigmoid of a Q8.8 logit, Q0.16 result (17 bits wide)
  function automatic logic [16:0] sigmoid_q16(input logic signed [LogitW-1:0] x);
    logic [16:0] a;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [23:0] p;
    logic [16:0] s;
    a  = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
    t0 = sig_tab({1'b0, a[10:6]});
    t1 = sig_tab({1'b0, a[10:6]} + 6'd1);
    p  = 24'(t1 - t0) * {18'd0, a[5:0]} + 24'd32;
    s  = (a >= 17'd2048) ? sig_tab(6'd32) : t0 + 17'(p[23:6]);
    return x[15] ? 17'(17'd65536 - s) : s;
  endfunction

  function automatic logic [17:0] anchor_tab(input logic [1:0] lvl,
                                             input logic [2:0] idx);
    logic [17:0] v;
    case ({lvl, idx})
      5'b00_000: v = {9'd10, 9'd13};
      5'b00_001: v = {9'd16, 9'd30};
      5'b00_010: v = {9'd33, 9'd23};
      5'b01_000: v = {9'd30, 9'd61};
      5'b01_001: v = {9'd62, 9'd45};
      5'b01_010: v = {9'd59, 9'd119};
      5'b10_000: v = {9'd116, 9'd90};
      5'b10_001: v = {9'd156, 9'd198};
      5'b10_010: v = {9'd373, 9'd326};
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/abd_if.sv
interface abd_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/abd_front.sv
module abd_front #(
  parameter int unsigned IMAGE_SIZE = 640
) (
  input  logic [abd_pkg::ConfW-1:0] thresh_i,
  abd_if.sink                   cell_if,
  output logic                  push_o,
  output abd_pkg::work_t        work_o,
  input  logic                  full_i
);
  import abd_pkg::*;

  localparam logic [CellW:0] Grid0 = (CellW+1)'(IMAGE_SIZE / 8);
  localparam logic [CellW:0] Grid1 = (CellW+1)'(IMAGE_SIZE / 16);
  localparam logic [CellW:0] Grid2 = (CellW+1)'(IMAGE_SIZE / 32);

  cell_t       c;
  logic [16:0] obj, fire, like;
  logic [CellW:0] grid;
  logic [17:0] anc;
  logic        keep;

  assign c       = cell_if.data;
  assign cell_if.ready = !full_i;

  always_comb begin
    case (c.scale_level)
      2'd0:    grid = Grid0;
      2'd1:    grid = Grid1;
      default: grid = Grid2;
    endcase
    obj  = sigmoid_q16(c.obj_logit);
    fire = sigmoid_q16(c.fire_logit);
    like = sigmoid_q16(c.like_logit);
    anc  = anchor_tab(c.scale_level, {1'b0, c.anchor_slot});
    keep = (c.scale_level != 2'd3) && (c.anchor_slot != 2'd3) &&
           ({1'b0, c.cell_col} < grid) && ({1'b0, c.cell_row} < grid) &&
           (obj > {1'b0, thresh_i}) && (fire > like);
  end

  assign push_o = cell_if.valid && cell_if.ready && keep;

  always_comb begin
    work_o.sx    = sigmoid_q16(c.tx_logit);
    work_o.sy    = sigmoid_q16(c.ty_logit);
    work_o.sw    = sigmoid_q16(c.tw_logit);
    work_o.sh    = sigmoid_q16(c.th_logit);
    work_o.obj   = obj;
    work_o.fire  = fire;
    work_o.col   = c.cell_col;
    work_o.row   = c.cell_row;
    work_o.lvl   = c.scale_level;
    work_o.anc_w = anc[17:9];
    work_o.anc_h = anc[8:0];
  end
endmodule

### design/abd_queue.sv
module abd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  abd_pkg::work_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output abd_pkg::work_t data_o,
  input  logic           pop_i
);
  import abd_pkg::*;

  work_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

### design/abd_back.sv
module abd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  abd_pkg::work_t work_i,
  output logic           pop_o,
  abd_if.source          box_if
);
  import abd_pkg::*;

  // stage 1 registers: centres in 2^-16 px (signed), squared size terms
  logic        v1_q;
  logic signed [31:0] cx_q, cy_q;
  logic [35:0] w2_q, h2_q;
  logic [8:0]  aw_q, ah_q;
  logic [31:0] sc_q;
  // stage 2 result register
  logic        v2_q;
  box_t        box_q;

  logic adv2, adv1;
  assign adv2  = !v2_q || box_if.ready;
  assign adv1  = !v1_q || adv2;
  assign pop_o = valid_i && adv1;

  logic [5:0]  stride;
  logic [23:0] ux, uy;
  logic [17:0] tw, th;
  always_comb begin
    stride = 6'd8 << work_i.lvl;
    ux = {6'd0, work_i.sx, 1'b0} + {1'b0, work_i.col, 16'd0};
    uy = {6'd0, work_i.sy, 1'b0} + {1'b0, work_i.row, 16'd0};
    tw = {work_i.sw, 1'b0};
    th = {work_i.sh, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      cx_q <= $signed({2'b0, 30'(ux) * 30'(stride)}) - $signed({11'd0, stride, 15'd0});
      cy_q <= $signed({2'b0, 30'(uy) * 30'(stride)}) - $signed({11'd0, stride, 15'd0});
      w2_q <= 36'(tw) * 36'(tw);
      h2_q <= 36'(th) * 36'(th);
      aw_q <= work_i.anc_w;
      ah_q <= work_i.anc_h;
      sc_q <= 32'(work_i.obj) * 32'(work_i.fire) + 32'd32768;
    end
  end

  // edges in 2^-33 px: c*2^17 -/+ w ; round at bit 29
  function automatic logic signed [15:0] edge_q4(input logic signed [50:0] v);
    logic signed [50:0] r;
    logic signed [21:0] q;
    r = v + 51'sd268435456;
    q = r[50:29];
    if (q > 22'sd32767) return 16'sd32767;
    if (q < -22'sd32768) return -16'sd32768;
    return q[15:0];
  endfunction

  logic signed [50:0] cxs, cys, ws, hs;
  always_comb begin
    cxs = {{2{cx_q[31]}}, cx_q, 17'd0};
    cys = {{2{cy_q[31]}}, cy_q, 17'd0};
    ws  = $signed({6'd0, 45'(w2_q) * 45'(aw_q)});
    hs  = $signed({6'd0, 45'(h2_q) * 45'(ah_q)});
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      box_q.box_left   <= edge_q4(cxs - ws);
      box_q.box_right  <= edge_q4(cxs + ws);
      box_q.box_top    <= edge_q4(cys - hs);
      box_q.box_bottom <= edge_q4(cys + hs);
      box_q.box_score  <= sc_q[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  assign box_if.valid = v2_q;
  assign box_if.data  = box_q;
endmodule

### design/anchor_box_decode_top.sv
// channel | dir | payload          | handshake
// cell    | in  | abd_pkg::cell_t  | valid/ready
// box     | out | abd_pkg::box_t   | valid/ready
// cfg     | in  | threshold        | write enable
//
// one cell per cycle unless box stalls; kept cells pass the queue and both back stages
// front classifies in the accept cycle, two-entry queue, two back stages
// cells failing threshold, class, level, anchor or grid checks are dropped
// reset clears queue and pipeline valids, threshold returns to 16384
// box stall backs up the pipe then the queue before cell ready falls
module anchor_box_decode_top #(
  parameter int unsigned IMAGE_SIZE = 640
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [abd_pkg::ConfW-1:0] cfg_wdata_i,
  abd_if.sink   cell_if,
  abd_if.source box_if
);
  import abd_pkg::*;

  logic [ConfW-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ConfThreshReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // front to queue
  logic  push, full, qv, pop;
  work_t wk_in, wk_out;

  abd_front #(.IMAGE_SIZE(IMAGE_SIZE)) u_front (
    .thresh_i(thr_q), .cell_if,
    .push_o(push), .work_o(wk_in), .full_i(full)
  );

  abd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wk_in), .full_o(full),
    .valid_o(qv), .data_o(wk_out), .pop_i(pop)
  );

  abd_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .work_i(wk_out), .pop_o(pop), .box_if
  );
endmodule

### sim/anchor_box_decode_top_test.sv
module anchor_box_decode_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import abd_pkg::*;

  localparam int unsigned ImgSize = 640;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 10;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ConfW-1:0] cfg_wdata_i;

  abd_if #(.T(cell_t)) cell_if ();
  abd_if #(.T(box_t))  box_if ();

  anchor_box_decode_top #(.IMAGE_SIZE(ImgSize)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cell_if    (cell_if.sink),
    .box_if     (box_if.source)
  );

  // testbench copy of the threshold register
  logic [ConfW-1:0] thresh_q;
  box_t expected_boxes[$];

  int unsigned mismatch_count;
  int unsigned boxes_seen;
  int unsigned cells_sent;
  int unsigned idle_cycles;
  bit          gaps_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sigmoid table, Q0.16 at logit k/4
  function automatic int unsigned sig_point(input int k);
    int unsigned pts[33] = '{
      32768, 36843, 40793, 44510, 47910, 50941, 53581, 55833,
      57724, 59287, 60565, 61597, 62427, 63090, 63615, 64030,
      64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
      65374, 65410, 65437, 65459, 65476, 65489, 65500, 65508,
      65514};
    return pts[k];
  endfunction

  function automatic int unsigned conf_of(input logic signed [15:0] logit);
    int          x;
    int unsigned a;
    int unsigned s;
    int unsigned i;
    int unsigned f;
    x = logit;
    a = (x < 0) ? -x : x;
    if (a >= 2048) begin
      s = sig_point(32);
    end else begin
      i = a >> 6;
      f = a & 63;
      s = sig_point(i) + (((sig_point(i + 1) - sig_point(i)) * f + 32) >> 6);
    end
    return (x < 0) ? 65536 - s : s;
  endfunction

  function automatic int unsigned anchor_dim(input int lvl, input int idx);
    int unsigned dims[9] = '{10, 13, 16, 30, 33, 23, 30, 61, 62};
    int unsigned dims2[9] = '{45, 59, 119, 116, 90, 156, 198, 373, 326};
    int n;
    n = lvl * 6 + idx;
    return (n < 9) ? dims[n] : dims2[n - 9];
  endfunction

  // edge in 2^-33 pixel units rounded half up to Q12.4 and saturated
  function automatic logic [15:0] round_edge(input longint v33);
    longint r;
    r = (v33 + (longint'(1) << 28)) >>> 29;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // decode one cell into a box, returns 0 when the cell is dropped
  function automatic bit decode_cell(input cell_t c, output box_t b);
    int unsigned stride;
    int unsigned obj;
    int unsigned fire;
    int unsigned like;
    longint      cx;
    longint      cy;
    longint      w;
    longint      h;
    longint      t;
    b = '0;
    if (c.scale_level > 2 || c.anchor_slot > 2) return 0;
    stride = 8 << c.scale_level;
    if (c.cell_col >= ImgSize / stride || c.cell_row >= ImgSize / stride) return 0;
    obj  = conf_of(c.obj_logit);
    fire = conf_of(c.fire_logit);
    like = conf_of(c.like_logit);
    if (!(obj > thresh_q && fire > like)) return 0;
    cx = ((longint'(2 * conf_of(c.tx_logit)) + longint'(c.cell_col) * 65536) * stride
          - longint'(stride) * 32768) * 131072;
    cy = ((longint'(2 * conf_of(c.ty_logit)) + longint'(c.cell_row) * 65536) * stride
          - longint'(stride) * 32768) * 131072;
    t = 2 * conf_of(c.tw_logit);
    w = t * t * anchor_dim(c.scale_level, c.anchor_slot * 2);
    t = 2 * conf_of(c.th_logit);
    h = t * t * anchor_dim(c.scale_level, c.anchor_slot * 2 + 1);
    b.box_left   = round_edge(cx - w);
    b.box_right  = round_edge(cx + w);
    b.box_top    = round_edge(cy - h);
    b.box_bottom = round_edge(cy + h);
    b.box_score  = 16'((longint'(obj) * fire + 32768) >> 16);
    return 1;
  endfunction

  // sink side: random backpressure while gaps are on, compare each beat with the oldest box
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_if.ready <= 1'b0;
    end else begin
      box_if.ready <= !gaps_on || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    box_t want;
    if (rst_ni && box_if.valid && box_if.ready) begin
      boxes_seen++;
      if (expected_boxes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected box %h", box_if.data);
      end else begin
        want = expected_boxes.pop_front();
        if (want.box_left !== box_if.data.box_left ||
            want.box_right !== box_if.data.box_right ||
            want.box_top !== box_if.data.box_top ||
            want.box_bottom !== box_if.data.box_bottom ||
            want.box_score !== box_if.data.box_score) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("box mismatch: exp l%0d r%0d t%0d b%0d s%0d got l%0d r%0d t%0d b%0d s%0d",
                     want.box_left, want.box_right, want.box_top, want.box_bottom,
                     want.box_score, box_if.data.box_left, box_if.data.box_right,
                     box_if.data.box_top, box_if.data.box_bottom, box_if.data.box_score);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((cell_if.valid && cell_if.ready) || (box_if.valid && box_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one cell; prediction is made on the accepting edge
  task automatic send_cell(input cell_t c);
    box_t b;
    while (gaps_on && $urandom_range(99) < 10) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid <= 1'b1;
    cell_if.data  <= c;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    if (decode_cell(c, b)) expected_boxes = {expected_boxes, b};
    cells_sent++;
  endtask

  task automatic drain_boxes();
    cell_if.valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_thresh(input logic [15:0] v);
    drain_boxes();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    thresh_q = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic cell_t rand_cell(input bit kept_bias);
    cell_t c;
    c = cell_t'(130'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if (kept_bias) begin
      c.scale_level = 2'($urandom_range(2));
      c.anchor_slot = 2'($urandom_range(2));
      c.cell_col = 7'($urandom_range((ImgSize >> (3 + c.scale_level)) - 1));
      c.cell_row = 7'($urandom_range((ImgSize >> (3 + c.scale_level)) - 1));
      c.obj_logit  = 16'($urandom_range(3000));
      c.fire_logit = 16'($urandom_range(2500));
      c.like_logit = -$signed(16'($urandom_range(2500)));
      c.tx_logit = 16'($urandom_range(2400) - 1200);
      c.ty_logit = 16'($urandom_range(2400) - 1200);
      c.tw_logit = 16'($urandom_range(2400) - 1200);
      c.th_logit = 16'($urandom_range(2400) - 1200);
    end
    return c;
  endfunction

  // directed cells: logit extremes, ties, bad level/anchor, off-grid cells
  task automatic test_directed();
    cell_t c;
    int    l;
    c = '0;
    c.obj_logit = 16'sd2048; c.fire_logit = 16'sd100; c.like_logit = -16'sd100;
    for (l = 0; l < 3; l++) begin
      c.scale_level = 2'(l); c.anchor_slot = 2'(l);
      c.cell_col = 7'((ImgSize >> (3 + l)) - 1); c.cell_row = 7'd0;
      c.tx_logit = 16'sh7fff; c.ty_logit = 16'sh8000;
      c.tw_logit = 16'sh7fff; c.th_logit = 16'sh8000;
      send_cell(c);
      c.cell_col = 7'(ImgSize >> (3 + l));
      send_cell(c);
      c.cell_col = 7'd0; c.cell_row = 7'h7f;
      send_cell(c);
    end
    c.cell_row = 7'd0;
    c.scale_level = 2'd3; send_cell(c);
    c.scale_level = 2'd0; c.anchor_slot = 2'd3; send_cell(c);
    c.anchor_slot = 2'd0;
    c.fire_logit = c.like_logit; send_cell(c);
    c.fire_logit = 16'sh7fff; c.like_logit = 16'sh8000; send_cell(c);
    c.obj_logit = 16'sh0000; send_cell(c);
    c.obj_logit = 16'sh0001; send_cell(c);
    c.obj_logit = 16'sh8000; send_cell(c);
    c.obj_logit = 16'sh7fff; c.tx_logit = 16'sh07ff; c.tw_logit = 16'sh0800;
    send_cell(c);
    c.tx_logit = 16'shf801; c.tw_logit = 16'shffc1; send_cell(c);
  endtask

  task automatic test_random(input int n, input bit gappy);
    int i;
    gaps_on = gappy;
    for (i = 0; i < n; i++) send_cell(rand_cell($urandom_range(99) < 80));
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cell_if.valid = 1'b0;
    cell_if.data = '0;
    thresh_q = ConfThreshReset;
    gaps_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(250, 1'b1);
    write_thresh(16'd0);
    test_random(150, 1'b0);
    write_thresh(16'hffff);
    test_directed();
    test_random(100, 1'b1);
    write_thresh(16'd60000);
    test_random(150, 1'b1);
    write_thresh(16'd16384);
    test_random(250, 1'b1);
    drain_boxes();

    $display("sent %0d cells, checked %0d boxes, over 5 threshold settings",
             cells_sent, boxes_seen);
    if (mismatch_count == 0 && expected_boxes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
